[src/uvs_pkg.sv]
`timescale 1ns / 1ps

package uvs_pkg;

    // Grid limits and field widths.
    localparam int MAX_RINGS   = 1024;
    localparam int MAX_SECTORS = 1024;
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 10;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RING_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SECTOR_COUNT = 2'd1;
    localparam logic [1:0] CFG_RADIUS       = 2'd2;

    // Input modes.
    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_INDEX  = 1'b1;

    // Long division: one quotient bit per stage.
    localparam int DIV_STEPS = 33;
    localparam int REM_W     = 11;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q;
    } t_div_res;

    // Shift one dividend bit into the partial remainder and subtract the divisor if it fits.
    function automatic t_div_res div_step(input logic [REM_W-1:0] rem,
                                          input logic             bit_in,
                                          input logic [REM_W-1:0] den);
        logic [REM_W:0] t;
        t_div_res       res;
        t = {rem, bit_in};
        if (t >= {1'b0, den}) begin
            res.rem = REM_W'(t - {1'b0, den});
            res.q   = 1'b1;
        end else begin
            res.rem = t[REM_W-1:0];
            res.q   = 1'b0;
        end
        return res;
    endfunction

    // Sine and cosine unit.
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
    localparam int PHASE_W      = 32;
    localparam int TRIG_W       = 16;

    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    localparam logic [31:0] CORDIC_ATAN [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef logic signed [TRIG_W-1:0] t_q15;
    typedef logic [PHASE_W-1:0]       t_phase;

endpackage

[src/uvs_cordic.sv]
`timescale 1ns / 1ps

module uvs_cordic import uvs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_phase i_phase,
    output logic   o_valid,
    output t_q15   o_cos,
    output t_q15   o_sin
);

    // Round half up to Q1.15 and saturate.
    function automatic t_q15 to_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [18:0] sh;
        t  = 34'(v) + 34'sd16384;
        sh = t[33:15];
        if (sh > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (sh < -19'sd32768) begin
            return 16'sh8000;
        end else begin
            return sh[15:0];
        end
    endfunction

    logic                r_vld [CORDIC_LAT];
    logic signed [31:0]  r_x   [CORDIC_ITERS+1];
    logic signed [31:0]  r_y   [CORDIC_ITERS+1];
    logic signed [31:0]  r_z   [CORDIC_ITERS+1];
    logic [1:0]          r_q   [CORDIC_ITERS+1];
    t_q15                r_cos;
    t_q15                r_sin;

    logic [31:0]         w_rot;
    logic [1:0]          w_q;
    logic [31:0]         w_d;
    logic signed [32:0]  w_x;
    logic signed [32:0]  w_y;
    logic signed [32:0]  w_c;
    logic signed [32:0]  w_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Fold the phase into the quadrant nearest to it.
    assign w_rot = i_phase + 32'h2000_0000;
    assign w_q   = w_rot[31:30];
    assign w_d   = i_phase - {w_q, 30'd0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_X0;
        r_y[0] <= 32'sd0;
        r_z[0] <= $signed(w_d);
        r_q[0] <= w_q;
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            r_q[i+1] <= r_q[i];
            if (!r_z[i][31]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - $signed(CORDIC_ATAN[i]);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + $signed(CORDIC_ATAN[i]);
            end
        end
    end

    assign w_x = 33'(r_x[CORDIC_ITERS]);
    assign w_y = 33'(r_y[CORDIC_ITERS]);

    always_comb begin
        unique case (r_q[CORDIC_ITERS])
            2'd0: begin
                w_c = w_x;
                w_s = w_y;
            end
            2'd1: begin
                w_c = -w_y;
                w_s = w_x;
            end
            2'd2: begin
                w_c = -w_x;
                w_s = -w_y;
            end
            default: begin
                w_c = w_y;
                w_s = -w_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cos <= to_q15(w_c);
        r_sin <= to_q15(w_s);
    end

    assign o_valid = r_vld[CORDIC_LAT-1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

[src/uv_sphere_mesh_generator_unit.sv]
`timescale 1ns / 1ps

// UV sphere mesh generator. Each transaction on the input names one grid cell (ring, sector)
// and a mode. In vertex mode the unit returns one result with the cell's position (signed
// Q8.8) and texture coordinates (unsigned Q2.14); in index mode it returns six results, the
// triangle corner indices of the cell, with o_last on the sixth. A cell whose ring or sector
// is at or beyond its count returns one all-zero result with o_bad_cell and o_last set. The
// datapath is a fixed pipeline of 70 register stages: an input register, a 33-stage long
// divider that forms the two angle phases and both texture coordinates, two 32-stage CORDIC
// units for the sines and cosines, three stages of multiplies and adds, and an output
// register. Vertex-mode transactions are taken every cycle while o_busy is low; an
// index-mode transaction raises o_busy, because the single output port sends its six
// results one after another. Results appear on the outputs for one cycle each with o_valid
// high and cannot be held off. There is no clearing pass after reset.
// The counts and radius may be written only while no transaction is in flight.

module uv_sphere_mesh_generator_unit import uvs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_mode,
    input  logic [IDX_W-1:0]    i_ring_index,
    input  logic [IDX_W-1:0]    i_sector_index,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    output logic signed [16:0]  o_pos_x,
    output logic signed [16:0]  o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic [15:0]         o_tex_u,
    output logic [15:0]         o_tex_v,
    output logic [19:0]         o_vertex_index,
    output logic                o_last,
    output logic                o_bad_cell
);

    localparam int LN_THETA  = 0;
    localparam int LN_PHI    = 1;
    localparam int LN_U      = 2;
    localparam int LN_V      = 3;
    localparam int DIV_LANES = 4;
    localparam int DL        = DIV_STEPS - 1;
    localparam int SL        = CORDIC_LAT - 1;

    localparam logic [2:0] HOLD_CYCLES = 3'd5;

    // Output sequencer phases for the last five corner indices of a cell.
    localparam logic [2:0] SEQ_IDLE = 3'd0;
    localparam logic [2:0] SEQ_SB_A = 3'd1;
    localparam logic [2:0] SEQ_TR_A = 3'd2;
    localparam logic [2:0] SEQ_TR_B = 3'd3;
    localparam logic [2:0] SEQ_SB_B = 3'd4;
    localparam logic [2:0] SEQ_TB   = 3'd5;

    // ------------------------------------------------------------------
    // Configuration registers and the effective counts.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_ring_count;
    logic [CNT_W-1:0] r_sector_count;
    logic [15:0]      r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count   <= CNT_W'(16);
            r_sector_count <= CNT_W'(16);
            r_radius       <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RING_COUNT:   r_ring_count   <= i_cfg_data[CNT_W-1:0];
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg_data[CNT_W-1:0];
                CFG_RADIUS:       r_radius       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A count below two acts as two and one above the maximum acts as the maximum.
    logic [CNT_W-1:0] w_nr;
    logic [CNT_W-1:0] w_ns;
    logic [CNT_W-1:0] w_nr_m1;
    logic [CNT_W-1:0] w_ns_m1;
    logic [IDX_W-1:0] w_dr;
    logic [IDX_W-1:0] w_ds;
    logic [REM_W-1:0] w_den [DIV_LANES];

    always_comb begin
        if (r_ring_count < CNT_W'(2)) begin
            w_nr = CNT_W'(2);
        end else if (r_ring_count > CNT_W'(MAX_RINGS)) begin
            w_nr = CNT_W'(MAX_RINGS);
        end else begin
            w_nr = r_ring_count;
        end
        if (r_sector_count < CNT_W'(2)) begin
            w_ns = CNT_W'(2);
        end else if (r_sector_count > CNT_W'(MAX_SECTORS)) begin
            w_ns = CNT_W'(MAX_SECTORS);
        end else begin
            w_ns = r_sector_count;
        end
    end

    assign w_nr_m1 = w_nr - CNT_W'(1);
    assign w_ns_m1 = w_ns - CNT_W'(1);
    assign w_dr    = w_nr_m1[IDX_W-1:0];
    assign w_ds    = w_ns_m1[IDX_W-1:0];

    // Every division has the form (n + d) / (2 d), which rounds n / (2 d) half up.
    assign w_den[LN_THETA] = {w_dr, 1'b0};
    assign w_den[LN_PHI]   = {w_ds, 1'b0};
    assign w_den[LN_U]     = {w_ds, 1'b0};
    assign w_den[LN_V]     = {w_dr, 1'b0};

    // ------------------------------------------------------------------
    // Input register. An index-mode transaction blocks the input so that
    // its six results leave the tail of the pipeline in empty slots.
    // ------------------------------------------------------------------
    logic             w_accept;
    logic [2:0]       r_hold_cnt;
    logic             r_s0_valid;
    logic             r_s0_mode;
    logic             r_s0_bad;
    logic [IDX_W-1:0] r_s0_r;
    logic [IDX_W-1:0] r_s0_s;

    assign o_busy   = (r_hold_cnt != 3'd0);
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cnt <= 3'd0;
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_accept;
            if (w_accept && (i_mode == MODE_INDEX)) begin
                r_hold_cnt <= HOLD_CYCLES;
            end else if (r_hold_cnt != 3'd0) begin
                r_hold_cnt <= r_hold_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_mode <= i_mode;
        r_s0_r    <= i_ring_index;
        r_s0_s    <= i_sector_index;
        r_s0_bad  <= ({1'b0, i_ring_index} >= w_nr) || ({1'b0, i_sector_index} >= w_ns);
    end

    // ------------------------------------------------------------------
    // Long divider: four lanes, one quotient bit per stage.
    //   theta phase = (r * 2^32 + dr) / (2 dr)
    //   phi phase   = (s * 2^33 + ds) / (2 ds), low 32 bits
    //   tex u       = ((S - s) * 2^15 + ds) / (2 ds)
    //   tex v       = ((R - r) * 2^15 + dr) / (2 dr)
    // The high part of the theta and phi dividends is already below the
    // divisor, so it is loaded as the starting remainder.
    // ------------------------------------------------------------------
    logic                 r_dv_valid [DIV_STEPS];
    logic                 r_dv_mode  [DIV_STEPS];
    logic                 r_dv_bad   [DIV_STEPS];
    logic [IDX_W-1:0]     r_dv_r     [DIV_STEPS];
    logic [IDX_W-1:0]     r_dv_s     [DIV_STEPS];
    logic [REM_W-1:0]     r_dv_rem   [DIV_STEPS][DIV_LANES];
    logic [DIV_STEPS-1:0] r_dv_q     [DIV_STEPS][DIV_LANES];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int BIT = DIV_STEPS - 1 - k;

        logic                 in_valid;
        logic                 in_mode;
        logic                 in_bad;
        logic [IDX_W-1:0]     in_r;
        logic [IDX_W-1:0]     in_s;
        logic [REM_W-1:0]     in_rem  [DIV_LANES];
        logic [DIV_STEPS-1:0] in_q    [DIV_LANES];
        logic [DIV_STEPS-1:0] strm    [DIV_LANES];
        t_div_res             res     [DIV_LANES];

        if (k == 0) begin : g_first
            always_comb begin
                in_valid         = r_s0_valid;
                in_mode          = r_s0_mode;
                in_bad           = r_s0_bad;
                in_r             = r_s0_r;
                in_s             = r_s0_s;
                in_rem[LN_THETA] = {2'b00, r_s0_r[IDX_W-1:1]};
                in_rem[LN_PHI]   = {1'b0, r_s0_s};
                in_rem[LN_U]     = '0;
                in_rem[LN_V]     = '0;
                for (int l = 0; l < DIV_LANES; l++) begin
                    in_q[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                in_valid = r_dv_valid[k-1];
                in_mode  = r_dv_mode[k-1];
                in_bad   = r_dv_bad[k-1];
                in_r     = r_dv_r[k-1];
                in_s     = r_dv_s[k-1];
                for (int l = 0; l < DIV_LANES; l++) begin
                    in_rem[l] = r_dv_rem[k-1][l];
                    in_q[l]   = r_dv_q[k-1][l];
                end
            end
        end

        always_comb begin
            strm[LN_THETA] = {in_r[0], 22'd0, w_dr};
            strm[LN_PHI]   = {23'd0, w_ds};
            strm[LN_U]     = {7'd0, w_ns - {1'b0, in_s}, 5'd0, w_ds};
            strm[LN_V]     = {7'd0, w_nr - {1'b0, in_r}, 5'd0, w_dr};
            for (int l = 0; l < DIV_LANES; l++) begin
                res[l] = div_step(in_rem[l], strm[l][BIT], w_den[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else begin
                r_dv_valid[k] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_mode[k] <= in_mode;
            r_dv_bad[k]  <= in_bad;
            r_dv_r[k]    <= in_r;
            r_dv_s[k]    <= in_s;
            for (int l = 0; l < DIV_LANES; l++) begin
                r_dv_rem[k][l] <= res[l].rem;
                r_dv_q[k][l]   <= {in_q[l][DIV_STEPS-2:0], res[l].q};
            end
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine of both angles, with the rest of the transaction
    // carried alongside through a matching delay line.
    // ------------------------------------------------------------------
    logic w_ct_valid;
    logic w_cp_valid;
    t_q15 w_cos_t;
    t_q15 w_sin_t;
    t_q15 w_cos_p;
    t_q15 w_sin_p;

    uvs_cordic u_cordic_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv_valid[DL]),
        .i_phase (r_dv_q[DL][LN_THETA][PHASE_W-1:0]),
        .o_valid (w_ct_valid),
        .o_cos   (w_cos_t),
        .o_sin   (w_sin_t)
    );

    uvs_cordic u_cordic_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv_valid[DL]),
        .i_phase (r_dv_q[DL][LN_PHI][PHASE_W-1:0]),
        .o_valid (w_cp_valid),
        .o_cos   (w_cos_p),
        .o_sin   (w_sin_p)
    );

    logic             r_sd_valid [CORDIC_LAT];
    logic             r_sd_mode  [CORDIC_LAT];
    logic             r_sd_bad   [CORDIC_LAT];
    logic [IDX_W-1:0] r_sd_r     [CORDIC_LAT];
    logic [IDX_W-1:0] r_sd_s     [CORDIC_LAT];
    logic [15:0]      r_sd_u     [CORDIC_LAT];
    logic [15:0]      r_sd_v     [CORDIC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_LAT; k++) begin
                r_sd_valid[k] <= 1'b0;
            end
        end else begin
            r_sd_valid[0] <= r_dv_valid[DL];
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_sd_valid[k] <= r_sd_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd_mode[0] <= r_dv_mode[DL];
        r_sd_bad[0]  <= r_dv_bad[DL];
        r_sd_r[0]    <= r_dv_r[DL];
        r_sd_s[0]    <= r_dv_s[DL];
        r_sd_u[0]    <= r_dv_q[DL][LN_U][15:0];
        r_sd_v[0]    <= r_dv_q[DL][LN_V][15:0];
        for (int k = 1; k < CORDIC_LAT; k++) begin
            r_sd_mode[k] <= r_sd_mode[k-1];
            r_sd_bad[k]  <= r_sd_bad[k-1];
            r_sd_r[k]    <= r_sd_r[k-1];
            r_sd_s[k]    <= r_sd_s[k-1];
            r_sd_u[k]    <= r_sd_u[k-1];
            r_sd_v[k]    <= r_sd_v[k-1];
        end
    end

    // ------------------------------------------------------------------
    // First product stage: radius times sin(theta) and cos(theta); the
    // wrapped neighbor ring and sector for index mode.
    // ------------------------------------------------------------------
    logic signed [16:0] w_rad_s;
    logic [CNT_W-1:0]   w_r_inc;
    logic [CNT_W-1:0]   w_s_inc;

    logic               r_p1_valid;
    logic               r_p1_mode;
    logic               r_p1_bad;
    logic [IDX_W-1:0]   r_p1_r;
    logic [IDX_W-1:0]   r_p1_s;
    logic [IDX_W-1:0]   r_p1_b;
    logic [IDX_W-1:0]   r_p1_t;
    logic [15:0]        r_p1_u;
    logic [15:0]        r_p1_v;
    logic signed [32:0] r_p1_rst;
    logic signed [32:0] r_p1_rct;
    t_q15               r_p1_cp;
    t_q15               r_p1_sp;

    assign w_rad_s = $signed({1'b0, r_radius});
    assign w_r_inc = {1'b0, r_sd_r[SL]} + CNT_W'(1);
    assign w_s_inc = {1'b0, r_sd_s[SL]} + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= r_sd_valid[SL];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_mode <= r_sd_mode[SL];
        r_p1_bad  <= r_sd_bad[SL];
        r_p1_r    <= r_sd_r[SL];
        r_p1_s    <= r_sd_s[SL];
        r_p1_u    <= r_sd_u[SL];
        r_p1_v    <= r_sd_v[SL];
        r_p1_b    <= (w_r_inc == w_nr) ? '0 : w_r_inc[IDX_W-1:0];
        r_p1_t    <= (w_s_inc == w_ns) ? '0 : w_s_inc[IDX_W-1:0];
        r_p1_rst  <= w_rad_s * w_sin_t;
        r_p1_rct  <= w_rad_s * w_cos_t;
        r_p1_cp   <= w_cos_p;
        r_p1_sp   <= w_sin_p;
    end

    // ------------------------------------------------------------------
    // Second product stage: the phi factor, the rounded y, and the row
    // offsets of the two rings.
    // ------------------------------------------------------------------
    logic signed [33:0] w_py_sum;

    logic               r_p2_valid;
    logic               r_p2_mode;
    logic               r_p2_bad;
    logic [IDX_W-1:0]   r_p2_s;
    logic [IDX_W-1:0]   r_p2_t;
    logic [15:0]        r_p2_u;
    logic [15:0]        r_p2_v;
    logic signed [48:0] r_p2_px;
    logic signed [48:0] r_p2_pz;
    logic signed [16:0] r_p2_py;
    logic [20:0]        r_p2_yw;
    logic [20:0]        r_p2_bw;

    assign w_py_sum = 34'sd16384 - 34'(r_p1_rct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_mode <= r_p1_mode;
        r_p2_bad  <= r_p1_bad;
        r_p2_s    <= r_p1_s;
        r_p2_t    <= r_p1_t;
        r_p2_u    <= r_p1_u;
        r_p2_v    <= r_p1_v;
        r_p2_px   <= r_p1_rst * r_p1_cp;
        r_p2_pz   <= r_p1_rst * r_p1_sp;
        r_p2_py   <= w_py_sum[31:15];
        r_p2_yw   <= 21'(r_p1_r) * 21'(w_ns);
        r_p2_bw   <= 21'(r_p1_b) * 21'(w_ns);
    end

    // ------------------------------------------------------------------
    // Third stage: rounding of x and z, and the four distinct corners.
    // ------------------------------------------------------------------
    logic signed [48:0] w_px_sum;
    logic signed [48:0] w_pz_sum;
    logic [20:0]        w_c_sr;
    logic [20:0]        w_c_sb;
    logic [20:0]        w_c_tr;
    logic [20:0]        w_c_tb;

    logic               r_p3_valid;
    logic               r_p3_mode;
    logic               r_p3_bad;
    logic [15:0]        r_p3_u;
    logic [15:0]        r_p3_v;
    logic signed [16:0] r_p3_px;
    logic signed [16:0] r_p3_py;
    logic signed [16:0] r_p3_pz;
    logic [19:0]        r_p3_sr;
    logic [19:0]        r_p3_sb;
    logic [19:0]        r_p3_tr;
    logic [19:0]        r_p3_tb;

    assign w_px_sum = r_p2_px + 49'sd536870912;
    assign w_pz_sum = r_p2_pz + 49'sd536870912;
    assign w_c_sr   = r_p2_yw + 21'(r_p2_s);
    assign w_c_sb   = r_p2_bw + 21'(r_p2_s);
    assign w_c_tr   = r_p2_yw + 21'(r_p2_t);
    assign w_c_tb   = r_p2_bw + 21'(r_p2_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3_mode <= r_p2_mode;
        r_p3_bad  <= r_p2_bad;
        r_p3_u    <= r_p2_u;
        r_p3_v    <= r_p2_v;
        r_p3_px   <= w_px_sum[46:30];
        r_p3_pz   <= w_pz_sum[46:30];
        r_p3_py   <= r_p2_py;
        r_p3_sr   <= w_c_sr[19:0];
        r_p3_sb   <= w_c_sb[19:0];
        r_p3_tr   <= w_c_tr[19:0];
        r_p3_tb   <= w_c_tb[19:0];
    end

    // ------------------------------------------------------------------
    // Output stage. A vertex or a bad cell leaves as a single result; a
    // cell in index mode leaves its first corner at once and the other
    // five from the hold registers while the pipeline tail is empty.
    // ------------------------------------------------------------------
    logic [2:0]         r_seq_cnt;
    logic [19:0]        r_hold_sb;
    logic [19:0]        r_hold_tr;
    logic [19:0]        r_hold_tb;

    logic               r_out_valid;
    logic signed [16:0] r_out_px;
    logic signed [16:0] r_out_py;
    logic signed [16:0] r_out_pz;
    logic [15:0]        r_out_u;
    logic [15:0]        r_out_v;
    logic [19:0]        r_out_idx;
    logic               r_out_last;
    logic               r_out_bad;

    logic               n_out_valid;
    logic signed [16:0] n_out_px;
    logic signed [16:0] n_out_py;
    logic signed [16:0] n_out_pz;
    logic [15:0]        n_out_u;
    logic [15:0]        n_out_v;
    logic [19:0]        n_out_idx;
    logic               n_out_last;
    logic               n_out_bad;
    logic [2:0]         n_seq_cnt;
    logic               n_hold_load;

    always_comb begin
        n_out_valid = 1'b0;
        n_out_px    = '0;
        n_out_py    = '0;
        n_out_pz    = '0;
        n_out_u     = '0;
        n_out_v     = '0;
        n_out_idx   = '0;
        n_out_last  = 1'b0;
        n_out_bad   = 1'b0;
        n_seq_cnt   = r_seq_cnt;
        n_hold_load = 1'b0;
        if (r_seq_cnt != SEQ_IDLE) begin
            n_out_valid = 1'b1;
            n_seq_cnt   = r_seq_cnt + 3'd1;
            unique case (r_seq_cnt)
                SEQ_SB_A: n_out_idx = r_hold_sb;
                SEQ_TR_A: n_out_idx = r_hold_tr;
                SEQ_TR_B: n_out_idx = r_hold_tr;
                SEQ_SB_B: n_out_idx = r_hold_sb;
                SEQ_TB: begin
                    n_out_idx  = r_hold_tb;
                    n_out_last = 1'b1;
                    n_seq_cnt  = SEQ_IDLE;
                end
                default: n_seq_cnt = SEQ_IDLE;
            endcase
        end else if (r_p3_valid) begin
            n_out_valid = 1'b1;
            if (r_p3_bad) begin
                n_out_last = 1'b1;
                n_out_bad  = 1'b1;
            end else if (r_p3_mode == MODE_VERTEX) begin
                n_out_px   = r_p3_px;
                n_out_py   = r_p3_py;
                n_out_pz   = r_p3_pz;
                n_out_u    = r_p3_u;
                n_out_v    = r_p3_v;
                n_out_last = 1'b1;
            end else begin
                n_out_idx   = r_p3_sr;
                n_seq_cnt   = SEQ_SB_A;
                n_hold_load = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_cnt   <= SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_seq_cnt   <= n_seq_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_px   <= n_out_px;
        r_out_py   <= n_out_py;
        r_out_pz   <= n_out_pz;
        r_out_u    <= n_out_u;
        r_out_v    <= n_out_v;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
        if (n_hold_load) begin
            r_hold_sb <= r_p3_sb;
            r_hold_tr <= r_p3_tr;
            r_hold_tb <= r_p3_tb;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pos_x        = r_out_px;
    assign o_pos_y        = r_out_py;
    assign o_pos_z        = r_out_pz;
    assign o_tex_u        = r_out_u;
    assign o_tex_v        = r_out_v;
    assign o_vertex_index = r_out_idx;
    assign o_last         = r_out_last;
    assign o_bad_cell     = r_out_bad;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Both sine and cosine units stay in step with the side delay line.
    a_cordic_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ct_valid == r_sd_valid[SL]) && (w_cp_valid == r_sd_valid[SL]))
        else $error("sine/cosine pipeline out of step with side data");

    // While the corner sequence plays out, no transaction may reach the tail.
    a_tail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_cnt != SEQ_IDLE) |-> !r_p3_valid)
        else $error("transaction reached the output stage during a corner sequence");

    // An accepted index-mode transaction blocks the input on the next cycle.
    a_index_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == MODE_INDEX)) |=> o_busy)
        else $error("input not blocked after an index-mode transaction");

    // A bad cell is always a single, final result.
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_cell) |-> (o_last && (r_seq_cnt == SEQ_IDLE)))
        else $error("bad cell result is not a single final result");

endmodule

[test/uv_sphere_mesh_generator_unit_test.sv]
`timescale 1ns / 1ps

module uv_sphere_mesh_generator_unit_test;
    import uvs_pkg::*;

    // Every transaction sent to the unit is run through a local predictor, which forms the
    // expected results: one vertex, six triangle corner indices, or one flagged zero result
    // for a cell outside the grid. The predictions wait in a FIFO. A monitor compares every
    // result strobe, field by field, against the oldest prediction. The test tasks run in
    // turn. First come the corners of the default grid, then small, clamped and maximal
    // grids with extreme radii, then a write to an unknown register index. Three random
    // phases follow, with a sender idle chance of 23 percent, then 45, then zero.
    // The counts and the radius change only while the pipeline is drained.

    typedef struct {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [19:0]        vertex_index;
        logic               last;
        logic               bad_cell;
    } t_cell_result;

    localparam int PIPE_DEPTH   = 69;
    localparam int CYCLE_LIMIT  = 300000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_mode = MODE_VERTEX;
    logic [IDX_W-1:0]   i_ring_index = '0;
    logic [IDX_W-1:0]   i_sector_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_RING_COUNT;
    logic [15:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [16:0] o_pos_x;
    logic signed [16:0] o_pos_y;
    logic signed [16:0] o_pos_z;
    logic [15:0]        o_tex_u;
    logic [15:0]        o_tex_v;
    logic [19:0]        o_vertex_index;
    logic               o_last;
    logic               o_bad_cell;

    uv_sphere_mesh_generator_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers, as written.
    logic [10:0] ring_reg = 11'd16;
    logic [10:0] sector_reg = 11'd16;
    logic [15:0] radius_reg = 16'd256;

    t_cell_result pending_results[$];
    int           idle_pct = 0;
    bit           failed = 1'b0;
    int           cycle_count = 0;

    function automatic int eff_count(input logic [10:0] n, input int max_n);
        if (n < 2) return 2;
        if (n > max_n) return max_n;
        return n;
    endfunction

    // Rounds a Q1.30 value half up to Q1.15 and saturates.
    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // Rotation-mode CORDIC after folding the phase into its nearest quadrant.
    task automatic sine_cosine(input logic [31:0] phase, output longint cos_q, sin_q);
        logic [1:0]  quad;
        logic [31:0] resid;
        longint      x, y, z, nx, ny, c, s;
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {quad, 30'b0};
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(CORDIC_ATAN[i]);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(CORDIC_ATAN[i]);
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        cos_q = round_q15(c);
        sin_q = round_q15(s);
    endtask

    function automatic longint tex_ratio(input longint num, input longint den);
        return ((num * 32768) + den) / (2 * den);
    endfunction

    // Works out the results of one cell and queues them.
    task automatic predict_cell(input logic mode, input int r, input int s);
        t_cell_result res;
        int           nr, ns, right, bottom;
        longint       dr, ds, rad, ct, st, cp, sp;
        logic [31:0]  ph_theta, ph_phi;
        longint       corner[6];
        nr = eff_count(ring_reg, MAX_RINGS);
        ns = eff_count(sector_reg, MAX_SECTORS);
        res = '{default: '0};
        if (r >= nr || s >= ns) begin
            res.last = 1'b1;
            res.bad_cell = 1'b1;
            pending_results = {pending_results, res};
        end else if (mode == MODE_VERTEX) begin
            dr = nr - 1;
            ds = ns - 1;
            ph_theta = 32'(((longint'(r) << 32) + dr) / (2 * dr));
            ph_phi   = 32'(((longint'(s) << 33) + ds) / (2 * ds));
            sine_cosine(ph_theta, ct, st);
            sine_cosine(ph_phi, cp, sp);
            rad = radius_reg;
            res.pos_x = 17'((rad * cp * st + (64'sd1 <<< 29)) >>> 30);
            res.pos_z = 17'((rad * sp * st + (64'sd1 <<< 29)) >>> 30);
            res.pos_y = 17'((-rad * ct + (64'sd1 <<< 14)) >>> 15);
            res.tex_u = 16'(tex_ratio(ns - s, ns - 1));
            res.tex_v = 16'(tex_ratio(nr - r, nr - 1));
            res.last  = 1'b1;
            pending_results = {pending_results, res};
        end else begin
            right  = (s + 1) % ns;
            bottom = (r + 1) % nr;
            corner[0] = s + r * ns;
            corner[1] = s + bottom * ns;
            corner[2] = right + r * ns;
            corner[3] = right + r * ns;
            corner[4] = s + bottom * ns;
            corner[5] = right + bottom * ns;
            for (int k = 0; k < 6; k++) begin
                res.vertex_index = 20'(corner[k]);
                res.last = (k == 5);
                pending_results = {pending_results, res};
            end
        end
    endtask

    // Presents one cell, waits for the accepting edge, then idles the sender in a share of
    // idle_pct cycles out of a hundred. Entered and left just after a rising edge.
    task automatic send_cell(input logic mode, input int r, input int s);
        i_start        <= 1'b1;
        i_mode         <= mode;
        i_ring_index   <= IDX_W'(r);
        i_sector_index <= IDX_W'(s);
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_cell(mode, r, s);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Lets every transaction in flight finish before the next register write.
    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_RING_COUNT:   ring_reg = data[10:0];
            CFG_SECTOR_COUNT: sector_reg = data[10:0];
            CFG_RADIUS:       radius_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [15:0] rings, input logic [15:0] sectors,
                            input logic [15:0] radius);
        drain();
        write_reg(CFG_RING_COUNT, rings);
        write_reg(CFG_SECTOR_COUNT, sectors);
        write_reg(CFG_RADIUS, radius);
    endtask

    // Both modes at the corners of the reset grid, plus cells outside it.
    task automatic test_default_grid;
        send_cell(MODE_VERTEX, 0, 0);
        send_cell(MODE_VERTEX, 15, 15);
        send_cell(MODE_VERTEX, 7, 4);
        send_cell(MODE_INDEX, 0, 0);
        send_cell(MODE_INDEX, 15, 15);
        send_cell(MODE_VERTEX, 16, 0);
        send_cell(MODE_INDEX, 0, 16);
        send_cell(MODE_INDEX, 1023, 1023);
    endtask

    // Smallest grid at full radius, counts below two, counts above the maximum, zero radius.
    task automatic test_grid_extremes;
        set_grid(16'd2, 16'd2, 16'hFFFF);
        send_cell(MODE_VERTEX, 0, 0);
        send_cell(MODE_VERTEX, 1, 1);
        send_cell(MODE_INDEX, 1, 1);
        send_cell(MODE_VERTEX, 2, 0);
        set_grid(16'd0, 16'd1, 16'd1);
        send_cell(MODE_VERTEX, 1, 0);
        send_cell(MODE_INDEX, 0, 1);
        send_cell(MODE_INDEX, 0, 2);
        set_grid(16'hFFFF, 16'h07FF, 16'd0);
        send_cell(MODE_VERTEX, 1023, 1023);
        send_cell(MODE_INDEX, 1023, 1023);
        send_cell(MODE_VERTEX, 512, 341);
    endtask

    // A write to an unused register index must leave the grid alone.
    task automatic test_unknown_register;
        drain();
        write_reg(2'd3, 16'hFFFF);
        send_cell(MODE_VERTEX, 300, 700);
        send_cell(MODE_INDEX, 1022, 1023);
    endtask

    // Random cells, mostly inside the grid, against a given grid and sender idle rate.
    task automatic test_random_cells(input logic [15:0] rings, input logic [15:0] sectors,
                                     input int pct, input int n_items);
        int nr, ns, r, s;
        set_grid(rings, sectors, 16'($urandom));
        idle_pct = pct;
        nr = eff_count(ring_reg, MAX_RINGS);
        ns = eff_count(sector_reg, MAX_SECTORS);
        for (int n = 0; n < n_items; n++) begin
            r = ($urandom_range(99) < 85) ? $urandom_range(nr - 1) : $urandom_range(1023);
            s = ($urandom_range(99) < 85) ? $urandom_range(ns - 1) : $urandom_range(1023);
            send_cell(logic'($urandom_range(1)), r, s);
        end
        idle_pct = 0;
    endtask

    // Result monitor: each strobe is matched with the oldest prediction.
    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, vertex_index %0d", o_vertex_index);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, o_pos_x);
                    failed = 1'b1;
                end
                if (o_pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, o_pos_y);
                    failed = 1'b1;
                end
                if (o_pos_z !== want.pos_z) begin
                    $error("pos_z: expected %0d, got %0d", want.pos_z, o_pos_z);
                    failed = 1'b1;
                end
                if (o_tex_u !== want.tex_u) begin
                    $error("tex_u: expected %0d, got %0d", want.tex_u, o_tex_u);
                    failed = 1'b1;
                end
                if (o_tex_v !== want.tex_v) begin
                    $error("tex_v: expected %0d, got %0d", want.tex_v, o_tex_v);
                    failed = 1'b1;
                end
                if (o_vertex_index !== want.vertex_index) begin
                    $error("vertex_index: expected %0d, got %0d", want.vertex_index,
                           o_vertex_index);
                    failed = 1'b1;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    failed = 1'b1;
                end
                if (o_bad_cell !== want.bad_cell) begin
                    $error("bad_cell: expected %0d, got %0d", want.bad_cell, o_bad_cell);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("uv_sphere_mesh_generator_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_grid();
        test_grid_extremes();
        test_unknown_register();
        // The sender idle chance is 23 percent, then 45, then zero. The last phase uses the full
        // grid so that every bit of both indexes is exercised.
        test_random_cells(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)), 23, 34);
        test_random_cells(16'($urandom_range(3, 200)), 16'($urandom_range(2, 24)), 45, 33);
        test_random_cells(16'd1024, 16'd1024, 0, 33);

        drain();
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("uv_sphere_mesh_generator_unit regression: pass");
        end else begin
            $display("uv_sphere_mesh_generator_unit regression: fail");
        end
        $finish;
    end

endmodule

[uv_sphere_mesh_generator_unit.f]
src/uvs_pkg.sv
src/uvs_cordic.sv
src/uv_sphere_mesh_generator_unit.sv
test/uv_sphere_mesh_generator_unit_test.sv
